// ===== rtl/core/pti_pkg.sv =====
// Shared types and constants for the periodic timer table.
// Depends on nothing; every other file of the block uses it.
package pti_pkg;

  localparam int unsigned FuncW  = 2;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RepW   = 16;
  localparam int unsigned IdW    = 6;
  localparam int unsigned EvW    = 2;
  localparam int unsigned QDepth = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_DEL  = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic [EvW-1:0] {
    EV_ADD       = 2'd0,
    EV_DELETE    = 2'd1,
    EV_FIRE      = 2'd2,
    EV_TICK_DONE = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DEL,
    ST_TICK,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    func_e                   op;
    logic [TimeW-1:0]        now_ms;
    logic [TimeW-1:0]        period_ms;
    logic signed [RepW-1:0]  repeat_count;
    logic [IdW-1:0]          timer_id;
  } cmd_t;

endpackage

// ===== rtl/core/pti_in_if.sv =====
// Request channel of the periodic timer table: valid/ready plus request fields.
// Depends on pti_pkg for field widths.
interface pti_in_if;
  logic                            valid;
  logic                            ready;
  logic [pti_pkg::FuncW-1:0]       func;
  logic [pti_pkg::TimeW-1:0]       now_ms;
  logic [pti_pkg::TimeW-1:0]       period_ms;
  logic signed [pti_pkg::RepW-1:0] repeat_count;
  logic [pti_pkg::IdW-1:0]         timer_id;

  modport source (output valid, func, now_ms, period_ms, repeat_count, timer_id,
                  input ready);
  modport sink   (input valid, func, now_ms, period_ms, repeat_count, timer_id,
                  output ready);
endinterface

// ===== rtl/core/pti_out_if.sv =====
// Event channel of the periodic timer table: valid/ready plus event fields.
// Depends on pti_pkg for field widths.
interface pti_out_if;
  logic                      valid;
  logic                      ready;
  logic [pti_pkg::EvW-1:0]   event_res;
  logic [pti_pkg::IdW-1:0]   slot_id;
  logic                      last;

  modport source (output valid, event_res, slot_id, last, input ready);
  modport sink   (input valid, event_res, slot_id, last, output ready);
endinterface

// ===== rtl/core/pti_front.sv =====
// Front end: accepts requests, drops unused function codes and queues the rest.
// Depends on pti_pkg and pti_in_if.
module pti_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pti_in_if.sink        in_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output pti_pkg::cmd_t cmd_o
);
  import pti_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            q_mem [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            keep, push, pop;
  cmd_t            cmd_in;

  always_comb begin
    case (in_i.func)
      FUNC_ADD, FUNC_DEL, FUNC_TICK: keep = 1'b1;
      default:                       keep = 1'b0;
    endcase
  end

  assign cmd_in.op           = func_e'(in_i.func);
  assign cmd_in.now_ms       = in_i.now_ms;
  assign cmd_in.period_ms    = in_i.period_ms;
  assign cmd_in.repeat_count = in_i.repeat_count;
  assign cmd_in.timer_id     = in_i.timer_id;

  assign in_i.ready  = (cnt_q != CntW'(QDepth));
  // drop the unused code at the door
  assign push        = in_i.valid && in_i.ready && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/core/pti_back.sv =====
// Back end: slot table, slot walker for add and tick, and the event output register.
// Depends on pti_pkg and pti_out_if.
module pti_back #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  pti_pkg::cmd_t cmd_i,
  pti_out_if.source     out_o
);
  import pti_pkg::*;

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SlotW-1:0] LastIdx = SlotW'(NUM_SLOTS - 1);

  // slot table
  logic [TimeW-1:0]       mem_last   [NUM_SLOTS];
  logic [TimeW-1:0]       mem_period [NUM_SLOTS];
  logic signed [RepW-1:0] mem_repeat [NUM_SLOTS];
  logic [RepW-1:0]        mem_fired  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   active_q, active_d;

  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic             cmd_load;
  logic [SlotW-1:0] walk_idx_q, walk_idx_d;
  logic             walk_end_q, walk_end_d;
  logic             ex_valid_q, ex_valid_d;
  logic [SlotW-1:0] ex_idx_q, ex_idx_d;

  logic [TimeW-1:0]       rd_last_q, rd_period_q;
  logic signed [RepW-1:0] rd_repeat_q;
  logic [RepW-1:0]        rd_fired_q;
  logic                   rd_en;

  logic             wr_last_en, wr_cfg_en, wr_fired_en;
  logic [SlotW-1:0] wr_addr;
  logic [RepW-1:0]  wr_fired_data;

  logic             out_valid_q;
  event_e           out_event_q, ld_event;
  logic [IdW-1:0]   out_id_q, ld_id;
  logic             out_last_q, ld_last;
  logic             load, can_load;

  logic [TimeW-1:0] due;
  logic             ex_due, ex_forever, ex_final, ex_emit, adv;
  logic [IdW-1:0]   tid_m1;
  logic [SlotW-1:0] del_idx;
  logic             del_hit;

  assign can_load = !out_valid_q || out_o.ready;

  // deadline check on the slot held in the read registers from the last issued read
  assign due        = rd_last_q + rd_period_q;
  assign ex_due     = ex_valid_q && active_q[ex_idx_q] && (due <= cmd_q.now_ms);
  assign ex_forever = rd_repeat_q[RepW-1];
  assign ex_final   = !ex_forever && ($unsigned(rd_repeat_q) == rd_fired_q);
  assign ex_emit    = ex_due && !ex_final;
  assign adv        = !ex_emit || can_load;

  assign tid_m1  = cmd_q.timer_id - IdW'(1);
  assign del_idx = tid_m1[SlotW-1:0];
  assign del_hit = (cmd_q.timer_id != '0) && (cmd_q.timer_id <= IdW'(NUM_SLOTS))
                   && active_q[del_idx];

  always_comb begin
    state_d       = state_q;
    cmd_ready_o   = 1'b0;
    cmd_load      = 1'b0;
    walk_idx_d    = walk_idx_q;
    walk_end_d    = walk_end_q;
    ex_valid_d    = ex_valid_q;
    ex_idx_d      = ex_idx_q;
    rd_en         = 1'b0;
    wr_last_en    = 1'b0;
    wr_cfg_en     = 1'b0;
    wr_fired_en   = 1'b0;
    wr_addr       = walk_idx_q;
    wr_fired_data = '0;
    active_d      = active_q;
    load          = 1'b0;
    ld_event      = EV_ADD;
    ld_id         = '0;
    ld_last       = 1'b1;

    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_load   = 1'b1;
          walk_idx_d = '0;
          walk_end_d = 1'b0;
          ex_valid_d = 1'b0;
          case (cmd_i.op)
            FUNC_ADD:  state_d = ST_ADD;
            FUNC_DEL:  state_d = ST_DEL;
            FUNC_TICK: state_d = ST_TICK;
            default:   state_d = ST_IDLE;
          endcase
        end
      end

      ST_ADD: begin
        if (!active_q[walk_idx_q]) begin
          if (can_load) begin
            wr_last_en            = 1'b1;
            wr_cfg_en             = 1'b1;
            wr_fired_en           = 1'b1;
            active_d[walk_idx_q]  = 1'b1;
            load                  = 1'b1;
            ld_id                 = IdW'(walk_idx_q) + IdW'(1);
            state_d               = ST_IDLE;
          end
        end else if (walk_idx_q == LastIdx) begin
          // table full
          if (can_load) begin
            load    = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          walk_idx_d = walk_idx_q + SlotW'(1);
        end
      end

      ST_DEL: begin
        if (can_load) begin
          load     = 1'b1;
          ld_event = EV_DELETE;
          ld_id    = del_hit ? cmd_q.timer_id : '0;
          if (del_hit) begin
            active_d[del_idx] = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      ST_TICK: begin
        if (adv) begin
          // retire the slot in the execute stage
          if (ex_due) begin
            wr_addr    = ex_idx_q;
            wr_last_en = 1'b1;
            if (ex_final) begin
              active_d[ex_idx_q] = 1'b0;
            end else if (!ex_forever) begin
              wr_fired_en   = 1'b1;
              wr_fired_data = rd_fired_q + RepW'(1);
            end
          end
          if (ex_emit) begin
            load     = 1'b1;
            ld_event = EV_FIRE;
            ld_id    = IdW'(ex_idx_q) + IdW'(1);
            ld_last  = 1'b0;
          end
          // issue the next slot read
          if (!walk_end_q) begin
            rd_en      = 1'b1;
            ex_valid_d = 1'b1;
            ex_idx_d   = walk_idx_q;
            if (walk_idx_q == LastIdx) begin
              walk_end_d = 1'b1;
            end else begin
              walk_idx_d = walk_idx_q + SlotW'(1);
            end
          end else begin
            ex_valid_d = 1'b0;
            state_d    = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (can_load) begin
          load     = 1'b1;
          ld_event = EV_TICK_DONE;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      walk_idx_q  <= '0;
      walk_end_q  <= 1'b0;
      ex_valid_q  <= 1'b0;
      ex_idx_q    <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      walk_idx_q <= walk_idx_d;
      walk_end_q <= walk_end_d;
      ex_valid_q <= ex_valid_d;
      ex_idx_q   <= ex_idx_d;
      active_q   <= active_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_load) begin
      cmd_q <= cmd_i;
    end
    if (load) begin
      out_event_q <= ld_event;
      out_id_q    <= ld_id;
      out_last_q  <= ld_last;
    end
  end

  // slot table write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_last_en) begin
      mem_last[wr_addr] <= cmd_q.now_ms;
    end
    if (wr_cfg_en) begin
      mem_period[wr_addr] <= cmd_q.period_ms;
      mem_repeat[wr_addr] <= cmd_q.repeat_count;
    end
    if (wr_fired_en) begin
      mem_fired[wr_addr] <= wr_fired_data;
    end
    if (rd_en) begin
      rd_last_q   <= mem_last[walk_idx_q];
      rd_period_q <= mem_period[walk_idx_q];
      rd_repeat_q <= mem_repeat[walk_idx_q];
      rd_fired_q  <= mem_fired[walk_idx_q];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_event_q;
  assign out_o.slot_id   = out_id_q;
  assign out_o.last      = out_last_q;

endmodule

// ===== rtl/core/periodic_timer_table.sv =====
// Periodic timer table with NUM_SLOTS slots. Requests (add, delete, tick) enter a
// two-entry queue and are carried out one at a time by a back end that owns the slot
// table. An add probes one slot per cycle until a free one is found. A tick reads
// every slot through the single read port of the slot table, which the walker visits
// once per slot per cycle while the event output is not stalled; a stalled event
// output holds a delete, an add or a tick alike. Ids are slot plus one.
// Depends on pti_pkg, pti_in_if, pti_out_if, pti_front and pti_back.
module periodic_timer_table #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pti_in_if.sink    in_i,
  pti_out_if.source out_o
);
  import pti_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  pti_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  pti_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

  a_fire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.event_res == EV_FIRE) |-> !out_o.last)
    else $error("fire event marked as last");

  a_fire_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.event_res == EV_FIRE)
      |-> (out_o.slot_id != '0) && (out_o.slot_id <= IdW'(NUM_SLOTS)))
    else $error("fire event with slot id out of range");

  a_tick_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.event_res == EV_TICK_DONE)
      |-> out_o.last && (out_o.slot_id == '0))
    else $error("tick done event malformed");

  a_cmd_only_when_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready && !cmd_valid |=> !out_o.valid || $stable(out_o.valid) || out_o.last
      || (out_o.event_res == EV_FIRE))
    else $error("event produced with no queued request");

endmodule
